@@ rtl/core/vn_pkg.sv @@
// Shared types for the vector normalisation pipeline.
package vn_pkg;

  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 15;
  localparam logic [15:0] UnitOne   = 16'd16384;

  typedef struct packed {
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
  } vn_in_t;

  typedef struct packed {
    logic        [15:0] magnitude;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
  } vn_out_t;

  // Per-item sideband carried alongside the root.
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][15:0] mag_abs;
  } vn_side_t;

  // One square-root stage.
  typedef struct packed {
    logic [31:0] rad;
    logic [15:0] root;
    logic [19:0] rem;
    vn_side_t    side;
  } vn_sqst_t;

  // One divider stage, three lanes sharing the divisor.
  typedef struct packed {
    logic [15:0]       mag;
    logic [2:0][15:0]  rem;
    logic [2:0][14:0]  num;
    logic [2:0][14:0]  quo;
    logic [2:0]        neg;
    logic              zero;
  } vn_dvst_t;

endpackage

@@ rtl/core/vn_sqrt.sv @@
// Pipelined square root, one root bit per stage.
module vn_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      rad_i,
  input  vn_pkg::vn_side_t side_i,
  output logic             valid_o,
  output logic [15:0]      root_o,
  output logic [19:0]      rem_o,
  output vn_pkg::vn_side_t side_o
);
  import vn_pkg::*;

  logic     [SqrtSteps-1:0] v_q;
  vn_sqst_t                 st_q [SqrtSteps];

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_step
    logic     v_in;
    vn_sqst_t s_in;
    vn_sqst_t s_d;
    logic [19:0] rem_sh;
    logic [19:0] trial;

    if (g == 0) begin : g_first
      assign v_in        = valid_i;
      assign s_in.rad    = rad_i;
      assign s_in.root   = '0;
      assign s_in.rem    = '0;
      assign s_in.side   = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign s_in = st_q[g-1];
    end

    always_comb begin
      rem_sh      = {s_in.rem[17:0], s_in.rad[31:30]};
      trial       = {2'b00, s_in.root, 2'b01};
      s_d         = s_in;
      s_d.rad     = {s_in.rad[29:0], 2'b00};
      if (rem_sh >= trial) begin
        s_d.rem  = rem_sh - trial;
        s_d.root = {s_in.root[14:0], 1'b1};
      end else begin
        s_d.rem  = rem_sh;
        s_d.root = {s_in.root[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= s_d;
      end
    end
  end

  assign valid_o = v_q[SqrtSteps-1];
  assign root_o  = st_q[SqrtSteps-1].root;
  assign rem_o   = st_q[SqrtSteps-1].rem;
  assign side_o  = st_q[SqrtSteps-1].side;

endmodule

@@ rtl/core/vn_div.sv @@
// Pipelined three-lane divider, one quotient bit per stage.
module vn_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  vn_pkg::vn_dvst_t st_i,
  output logic             valid_o,
  output vn_pkg::vn_dvst_t st_o
);
  import vn_pkg::*;

  logic     [DivSteps-1:0] v_q;
  vn_dvst_t                st_q [DivSteps];

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    logic     v_in;
    vn_dvst_t s_in;
    vn_dvst_t s_d;
    logic [2:0][16:0] sh;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign s_in = st_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign s_in = st_q[g-1];
    end

    always_comb begin
      s_d = s_in;
      for (int l = 0; l < 3; l++) begin
        sh[l]       = {s_in.rem[l], s_in.num[l][14]};
        s_d.num[l]  = {s_in.num[l][13:0], 1'b0};
        if (sh[l] >= {1'b0, s_in.mag}) begin
          s_d.rem[l] = 16'(sh[l] - {1'b0, s_in.mag});
          s_d.quo[l] = {s_in.quo[l][13:0], 1'b1};
        end else begin
          s_d.rem[l] = sh[l][15:0];
          s_d.quo[l] = {s_in.quo[l][13:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= s_d;
      end
    end
  end

  assign valid_o = v_q[DivSteps-1];
  assign st_o    = st_q[DivSteps-1];

endmodule

@@ rtl/core/vector3_normalize_core.sv @@
// Top level: 3D vector length and unit vector pipeline.
//
//   channel | signals                              | direction
//   input   | in_valid_i, in_stall_o, in_data_i    | vector in, Q8.8
//   output  | out_valid_o, out_stall_i, out_data_o | length Q8.8, unit Q1.14
//
// One item enters per cycle while in_stall_o is low; the stages are squares, sum,
// 16 root stages, rounding, 15 divider stages and the output register.
// Depth is set by the bit-per-stage root and quotient pipelines.
// Reset clears the valid bits only.
// A stalled full output register freezes every stage at once.
module vector3_normalize_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vn_pkg::vn_in_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vn_pkg::vn_out_t out_data_o
);
  import vn_pkg::*;

  logic en;

  // squares
  logic             sq_v_q;
  logic [2:0][30:0] sq_q;
  vn_side_t         sq_side_q;
  vn_side_t         side_d;

  // sum
  logic        sum_v_q;
  logic [31:0] sum_q;
  vn_side_t    sum_side_q;

  // root
  logic        rt_v;
  logic [15:0] rt_root;
  logic [19:0] rt_rem;
  vn_side_t    rt_side;

  // rounding
  logic        rd_v_q;
  vn_dvst_t    rd_q;
  vn_dvst_t    rd_d;
  logic [15:0] mag_d;
  logic [2:0][29:0] numer;

  // divider
  logic        dv_v;
  vn_dvst_t    dv_st;

  // output
  logic        out_v_q;
  vn_out_t     out_q;
  vn_out_t     out_d;
  logic [2:0][15:0] unit_d;
  logic [14:0] qs;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    side_d.neg[0]     = in_data_i.comp_x[15];
    side_d.neg[1]     = in_data_i.comp_y[15];
    side_d.neg[2]     = in_data_i.comp_z[15];
    side_d.mag_abs[0] = in_data_i.comp_x[15] ? 16'(-in_data_i.comp_x) : in_data_i.comp_x;
    side_d.mag_abs[1] = in_data_i.comp_y[15] ? 16'(-in_data_i.comp_y) : in_data_i.comp_y;
    side_d.mag_abs[2] = in_data_i.comp_z[15] ? 16'(-in_data_i.comp_z) : in_data_i.comp_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
      rd_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      sq_v_q  <= in_valid_i;
      sum_v_q <= sq_v_q;
      rd_v_q  <= rt_v;
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sq_q[l] <= {15'd0, side_d.mag_abs[l]} * {15'd0, side_d.mag_abs[l]};
      end
      sq_side_q  <= side_d;
      sum_q      <= 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
      sum_side_q <= sq_side_q;
      rd_q       <= rd_d;
      out_q      <= out_d;
    end
  end

  vn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sum_v_q),
    .rad_i   (sum_q),
    .side_i  (sum_side_q),
    .valid_o (rt_v),
    .root_o  (rt_root),
    .rem_o   (rt_rem),
    .side_o  (rt_side)
  );

  always_comb begin
    mag_d = (rt_rem > {4'd0, rt_root}) ? rt_root + 16'd1 : rt_root;
    rd_d.mag  = mag_d;
    rd_d.neg  = rt_side.neg;
    rd_d.zero = (mag_d == '0);
    for (int l = 0; l < 3; l++) begin
      numer[l]     = {rt_side.mag_abs[l][15:0], 14'd0} + {15'd0, mag_d[15:1]};
      rd_d.rem[l]  = {1'b0, numer[l][29:15]};
      rd_d.num[l]  = numer[l][14:0];
      rd_d.quo[l]  = '0;
    end
  end

  vn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rd_v_q),
    .st_i    (rd_q),
    .valid_o (dv_v),
    .st_o    (dv_st)
  );

  always_comb begin
    qs = '0;
    for (int l = 0; l < 3; l++) begin
      qs        = dv_st.quo[l];
      unit_d[l] = ({1'b0, qs} > UnitOne) ? UnitOne : {1'b0, qs};
      if (dv_st.zero) begin
        unit_d[l] = '0;
      end else if (dv_st.neg[l]) begin
        unit_d[l] = 16'(-unit_d[l]);
      end
    end
    out_d.magnitude = dv_st.mag;
    out_d.unit_x    = unit_d[0];
    out_d.unit_y    = unit_d[1];
    out_d.unit_z    = unit_d[2];
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_zero_units : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.magnitude == '0 |->
      out_q.unit_x == '0 && out_q.unit_y == '0 && out_q.unit_z == '0)
    else $error("zero length with nonzero unit component");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.unit_x <= 16384 && out_q.unit_x >= -16384 &&
      out_q.unit_y <= 16384 && out_q.unit_y >= -16384 &&
      out_q.unit_z <= 16384 && out_q.unit_z >= -16384)
    else $error("unit component out of range");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(sq_v_q) && $stable(sum_v_q) && $stable(rd_v_q))
    else $error("pipeline advanced while frozen");

endmodule
